/* src/izh_pkg.sv */
// Shared types, widths and helpers for the Izhikevich neuron step block.
`default_nettype none
package izh_pkg;

    localparam int FRAC_W_DEF    = 16;
    localparam int DATA_W        = 32;
    localparam int DT_W          = 17;
    localparam int CFG_IDX_W     = 3;
    localparam int MUL_W         = 33;
    localparam int PROD_W        = 2 * MUL_W;
    localparam int ACC_W         = 68;
    localparam int VSQ_W         = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RATE        = 3'd0,
        CFG_SENSITIVITY = 3'd1,
        CFG_RESET_POT   = 3'd2,
        CFG_JUMP        = 3'd3,
        CFG_TIME_STEP   = 3'd4
    } izh_cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_VV,
        ST_BV,
        ST_KLO,
        ST_AD,
        ST_KHI,
        ST_SDT,
        ST_BRK,
        ST_DV,
        ST_FIN
    } izh_state_t;

    // multiplier operand pairs
    typedef enum logic [2:0] {
        OP_NONE,
        OP_VV,
        OP_BV,
        OP_KLO,
        OP_AD,
        OP_KHI,
        OP_SDT,
        OP_DV
    } izh_op_t;

    // what the datapath takes from the product register this cycle
    typedef enum logic [2:0] {
        CAP_NONE,
        CAP_VSQ,
        CAP_DIFF,
        CAP_ACC_LO,
        CAP_SCALED,
        CAP_ACC_HI,
        CAP_DU_BRK,
        CAP_DV
    } izh_cap_t;

    typedef struct packed {
        logic     in_ready;
        logic     accept;
        izh_op_t  op;
        izh_cap_t cap;
    } izh_ctrl_t;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] x);
        logic signed [ACC_W-1:0] hi_lim;
        logic signed [ACC_W-1:0] lo_lim;
        hi_lim = $signed({{(ACC_W-DATA_W){1'b0}}, 1'b0, {(DATA_W-1){1'b1}}});
        lo_lim = $signed({{(ACC_W-DATA_W){1'b1}}, 1'b1, {(DATA_W-1){1'b0}}});
        if (x > hi_lim)
            return $signed({1'b0, {(DATA_W-1){1'b1}}});
        else if (x < lo_lim)
            return $signed({1'b1, {(DATA_W-1){1'b0}}});
        else
            return x[DATA_W-1:0];
    endfunction

endpackage
`default_nettype wire

/* src/izh_in_if.sv */
// Input channel: one current sample per word.
`default_nettype none
interface izh_in_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [izh_pkg::DATA_W-1:0]      input_current;

    modport source (output valid, output input_current, input ready);
    modport sink   (input valid, input input_current, output ready);
endinterface
`default_nettype wire

/* src/izh_out_if.sv */
// Output channel: neuron state after one tick per word.
`default_nettype none
interface izh_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [izh_pkg::DATA_W-1:0]      membrane;
    logic signed [izh_pkg::DATA_W-1:0]      recovery;
    logic                                   spike;

    modport source (output valid, output membrane, output recovery, output spike, input ready);
    modport sink   (input valid, input membrane, input recovery, input spike, output ready);
endinterface
`default_nettype wire

/* src/izhikevich_neuron_step.sv */
// Izhikevich neuron, one Euler tick per input word, on a shared multiplier.
// One tick at a time: a new input word is taken only once the last tick is done;
// seven products go through one registered
// 33x33 multiplier under a ten-step sequencer, plus one add/saturate step.
// The final step waits while the previous result word is still held downstream.
// Reset: v = -65, u = -13, no pending spike, config registers at their defaults.
`default_nettype none
module izhikevich_neuron_step #(
    parameter int FRAC_W = izh_pkg::FRAC_W_DEF
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    izh_in_if.sink                                      in_word,
    izh_out_if.source                                   out_word,
    input  wire logic                                   cfg_wr_en,
    input  wire logic [izh_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [izh_pkg::DATA_W-1:0]             cfg_wr_data
);

    localparam int DW = izh_pkg::DATA_W;
    localparam int AW = izh_pkg::ACC_W;
    localparam int MW = izh_pkg::MUL_W;
    localparam int PW = izh_pkg::PROD_W;
    localparam int TW = izh_pkg::DT_W;
    localparam int QW = izh_pkg::VSQ_W;

    // fixed-point constants, all scaled by 2^FRAC_W
    localparam logic signed [MW-1:0] K_004  = MW'((64'sd4 <<< FRAC_W) / 100);
    localparam logic signed [AW-1:0] K_140  = AW'(64'sd140 <<< FRAC_W);
    localparam logic signed [DW-1:0] K_30   = DW'(64'sd30 <<< FRAC_W);
    localparam logic signed [DW-1:0] V_RST  = DW'(-(64'sd65 <<< FRAC_W));
    localparam logic signed [DW-1:0] U_RST  = DW'(-(64'sd13 <<< FRAC_W));
    localparam logic signed [DW-1:0] A_RST  = DW'((64'sd2 <<< FRAC_W) / 100);
    localparam logic signed [DW-1:0] B_RST  = DW'((64'sd2 <<< FRAC_W) / 10);
    localparam logic signed [DW-1:0] D_RST  = DW'(64'sd8 <<< FRAC_W);
    localparam logic [TW-1:0]        DT_RST = TW'((64'sd1 <<< FRAC_W) / 10);

    // configuration
    logic signed [DW-1:0] a_reg;
    logic signed [DW-1:0] b_reg;
    logic signed [DW-1:0] c_reg;
    logic signed [DW-1:0] d_reg;
    logic [TW-1:0]        dt_reg;

    // neuron state
    logic signed [DW-1:0] v_reg;
    logic signed [DW-1:0] u_reg;
    logic                 spike_pend_reg;

    // working values of the current tick
    logic signed [DW-1:0] cur_reg;
    logic [QW-1:0]        vsq_reg;
    logic signed [DW-1:0] diff_reg;
    logic signed [AW-1:0] acc_reg;
    logic signed [DW-1:0] scaled_reg;
    logic signed [DW-1:0] bracket_reg;

    // result word
    logic                 out_valid_reg;
    logic signed [DW-1:0] membrane_reg;
    logic signed [DW-1:0] recovery_reg;
    logic                 spike_reg;

    izh_pkg::izh_ctrl_t   ctrl;
    logic                 out_free;
    logic signed [MW-1:0] op_x;
    logic signed [MW-1:0] op_y;
    logic                 mul_en;
    logic signed [PW-1:0] prod;
    logic signed [PW-1:0] prod_sh;
    logic signed [AW-1:0] prod_ext;
    logic signed [MW-1:0] dt_ext;
    logic signed [AW-1:0] bracket_sum;
    logic signed [DW-1:0] v_new;
    logic signed [DW-1:0] u_jump;

    assign out_free = !out_valid_reg || out_word.ready;

    izh_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_word.valid),
        .out_free (out_free),
        .ctrl     (ctrl)
    );

    assign in_word.ready = ctrl.in_ready;

    // operand selection for the shared multiplier
    assign dt_ext = $signed({{(MW-TW){1'b0}}, dt_reg});

    always_comb
    begin
        op_x = '0;
        op_y = '0;
        case (ctrl.op)
            izh_pkg::OP_VV:
            begin
                op_x = MW'(v_reg);
                op_y = MW'(v_reg);
            end
            izh_pkg::OP_BV:
            begin
                op_x = MW'(b_reg);
                op_y = MW'(v_reg);
            end
            izh_pkg::OP_KLO:
            begin
                // low half of v^2 taken as unsigned
                op_x = K_004;
                op_y = $signed({1'b0, vsq_reg[DW-1:0]});
            end
            izh_pkg::OP_AD:
            begin
                op_x = MW'(a_reg);
                op_y = MW'(diff_reg);
            end
            izh_pkg::OP_KHI:
            begin
                op_x = K_004;
                op_y = MW'($signed(vsq_reg[QW-1:DW]));
            end
            izh_pkg::OP_SDT:
            begin
                op_x = MW'(scaled_reg);
                op_y = dt_ext;
            end
            izh_pkg::OP_DV:
            begin
                op_x = MW'(bracket_reg);
                op_y = dt_ext;
            end
            default:
            begin
                op_x = '0;
                op_y = '0;
            end
        endcase
    end

    assign mul_en = (ctrl.op != izh_pkg::OP_NONE);

    izh_mul u_mul (
        .clk  (clk),
        .en   (mul_en),
        .op_x (op_x),
        .op_y (op_y),
        .prod (prod)
    );

    // arithmetic shift is a floor division by 2^FRAC_W
    assign prod_sh  = prod >>> FRAC_W;
    assign prod_ext = AW'(prod_sh);

    // 0.04 v^2 + 5v + 140 - u + I; 5v is exact, so no product is needed
    assign bracket_sum = (acc_reg >>> FRAC_W)
                       + (AW'(v_reg) <<< 2) + AW'(v_reg)
                       + K_140 - AW'(u_reg) + AW'(cur_reg);

    assign v_new  = izh_pkg::sat32(AW'(v_reg) + prod_ext);
    assign u_jump = izh_pkg::sat32(AW'(u_reg) + AW'(d_reg));

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg  <= A_RST;
            b_reg  <= B_RST;
            c_reg  <= V_RST;
            d_reg  <= D_RST;
            dt_reg <= DT_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                izh_pkg::CFG_RATE:        a_reg  <= $signed(cfg_wr_data);
                izh_pkg::CFG_SENSITIVITY: b_reg  <= $signed(cfg_wr_data);
                izh_pkg::CFG_RESET_POT:   c_reg  <= $signed(cfg_wr_data);
                izh_pkg::CFG_JUMP:        d_reg  <= $signed(cfg_wr_data);
                izh_pkg::CFG_TIME_STEP:   dt_reg <= cfg_wr_data[TW-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // neuron state and output handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg          <= V_RST;
            u_reg          <= U_RST;
            spike_pend_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            // spike reset from the previous tick is applied on entry
            if (ctrl.accept && spike_pend_reg)
            begin
                v_reg <= c_reg;
                u_reg <= u_jump;
            end
            if (ctrl.cap == izh_pkg::CAP_DU_BRK)
            begin
                // bracket_sum still sees the old u this cycle
                u_reg <= izh_pkg::sat32(AW'(u_reg) + prod_ext);
            end
            if (ctrl.cap == izh_pkg::CAP_DV)
            begin
                v_reg          <= v_new;
                spike_pend_reg <= (v_new >= K_30);
                out_valid_reg  <= 1'b1;
            end
            else if (out_word.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // working and result payload
    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            cur_reg <= in_word.input_current;
        end
        case (ctrl.cap)
            izh_pkg::CAP_VSQ:    vsq_reg    <= QW'(prod_sh);
            izh_pkg::CAP_DIFF:   diff_reg   <= izh_pkg::sat32(prod_ext - AW'(u_reg));
            // unshifted partial products; the bracket floors the full sum once
            izh_pkg::CAP_ACC_LO: acc_reg    <= AW'(prod);
            izh_pkg::CAP_SCALED: scaled_reg <= izh_pkg::sat32(prod_ext);
            izh_pkg::CAP_ACC_HI: acc_reg    <= acc_reg + (AW'(prod) <<< DW);
            izh_pkg::CAP_DU_BRK: bracket_reg <= izh_pkg::sat32(bracket_sum);
            izh_pkg::CAP_DV:
            begin
                membrane_reg <= v_new;
                recovery_reg <= u_reg;
                spike_reg    <= (v_new >= K_30);
            end
            default:
            begin
            end
        endcase
    end

    assign out_word.valid    = out_valid_reg;
    assign out_word.membrane = membrane_reg;
    assign out_word.recovery = recovery_reg;
    assign out_word.spike    = spike_reg;

    // one tick in flight at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_word.valid && in_word.ready) |=> !in_word.ready)
        else $error("input taken again straight after accept");

    // a result is only written into a free output slot
    a_finish_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.cap == izh_pkg::CAP_DV) |-> (!out_valid_reg || out_word.ready))
        else $error("result word overwritten before it was taken");

    // output valid rises only from the final sequencer step
    a_valid_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(ctrl.cap == izh_pkg::CAP_DV))
        else $error("output valid without a finished tick");

    // spike flag agrees with the threshold on the delivered membrane value
    a_spike_threshold: assert property (@(posedge clk) disable iff (!rst_n)
        out_word.valid |-> (out_word.spike == (out_word.membrane >= K_30)))
        else $error("spike flag disagrees with membrane value");

endmodule
`default_nettype wire

/* src/izh_mul.sv */
// Shared signed multiplier with registered product.
`default_nettype none
module izh_mul (
    input  wire logic                                  clk,
    input  wire logic                                  en,
    input  wire logic signed [izh_pkg::MUL_W-1:0]      op_x,
    input  wire logic signed [izh_pkg::MUL_W-1:0]      op_y,
    output logic signed [izh_pkg::PROD_W-1:0]          prod
);

    logic signed [izh_pkg::PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= op_x * op_y;
        end
    end

    assign prod = prod_reg;

endmodule
`default_nettype wire

/* src/izh_seq.sv */
// Step sequencer: schedules the shared multiplier and result captures.
`default_nettype none
module izh_seq (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               out_free,
    output izh_pkg::izh_ctrl_t      ctrl
);

    izh_pkg::izh_state_t state_reg;
    izh_pkg::izh_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= izh_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        ctrl.in_ready = 1'b0;
        ctrl.accept   = 1'b0;
        ctrl.op       = izh_pkg::OP_NONE;
        ctrl.cap      = izh_pkg::CAP_NONE;
        case (state_reg)
            izh_pkg::ST_IDLE:
            begin
                ctrl.in_ready = 1'b1;
                if (in_valid)
                begin
                    ctrl.accept = 1'b1;
                    state_next  = izh_pkg::ST_VV;
                end
            end
            izh_pkg::ST_VV:
            begin
                ctrl.op    = izh_pkg::OP_VV;
                state_next = izh_pkg::ST_BV;
            end
            izh_pkg::ST_BV:
            begin
                ctrl.op    = izh_pkg::OP_BV;
                ctrl.cap   = izh_pkg::CAP_VSQ;
                state_next = izh_pkg::ST_KLO;
            end
            izh_pkg::ST_KLO:
            begin
                ctrl.op    = izh_pkg::OP_KLO;
                ctrl.cap   = izh_pkg::CAP_DIFF;
                state_next = izh_pkg::ST_AD;
            end
            izh_pkg::ST_AD:
            begin
                ctrl.op    = izh_pkg::OP_AD;
                ctrl.cap   = izh_pkg::CAP_ACC_LO;
                state_next = izh_pkg::ST_KHI;
            end
            izh_pkg::ST_KHI:
            begin
                ctrl.op    = izh_pkg::OP_KHI;
                ctrl.cap   = izh_pkg::CAP_SCALED;
                state_next = izh_pkg::ST_SDT;
            end
            izh_pkg::ST_SDT:
            begin
                ctrl.op    = izh_pkg::OP_SDT;
                ctrl.cap   = izh_pkg::CAP_ACC_HI;
                state_next = izh_pkg::ST_BRK;
            end
            izh_pkg::ST_BRK:
            begin
                ctrl.cap   = izh_pkg::CAP_DU_BRK;
                state_next = izh_pkg::ST_DV;
            end
            izh_pkg::ST_DV:
            begin
                ctrl.op    = izh_pkg::OP_DV;
                state_next = izh_pkg::ST_FIN;
            end
            izh_pkg::ST_FIN:
            begin
                if (out_free)
                begin
                    ctrl.cap   = izh_pkg::CAP_DV;
                    state_next = izh_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = izh_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire
